/* rtl/mlpsg_pkg.sv */
// Shared types, constants and elaboration-time coefficient/table functions for the steering MLP.
package mlpsg_pkg;

  localparam int RAW_W       = 12;
  localparam int CMD_W       = 10;
  localparam int RULE_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int NUM_IN      = 3;
  localparam int UNIT_SLOTS  = 16;

  localparam logic [CMD_W-1:0] CMD_MAX = 10'd1000;

  // pipeline stage numbers
  localparam int ST_MUL_IN   = 0;
  localparam int ST_PRE      = 1;
  localparam int ST_IDX      = 2;
  localparam int ST_ROM      = 3;
  localparam int ST_MUL_OUT  = 4;
  localparam int ST_SUM      = 5;
  localparam int ST_CMD      = 6;
  localparam int PIPE_STAGES = 7;

  localparam int IN_SHIFT    = 10;

  typedef enum logic [RULE_W-1:0] {
    RULE_NET        = 3'd0,
    RULE_LEFT_LOST  = 3'd1,
    RULE_RIGHT_LOST = 3'd2,
    RULE_BOTH_LOST  = 3'd3,
    RULE_CROSS      = 3'd4
  } rule_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_THRESHOLD  = 2'd0,
    CFG_CROSS_THRESHOLD = 2'd1,
    CFG_CENTER_VALUE    = 2'd2
  } cfg_reg_t;

  // rule decision carried alongside the datapath
  typedef struct packed {
    rule_t             rule;
    logic [CMD_W-1:0]  cmd;
  } side_t;

  // network weights, units of 1e-9
  localparam longint W_IN_N [UNIT_SLOTS][NUM_IN] = '{
    '{ 64'sd539722819,  -64'sd726717240,  -64'sd880190624},
    '{ 64'sd884184831,   64'sd888344912,   64'sd1065046165},
    '{ 64'sd99650685,   -64'sd1874082184,  64'sd201617474},
    '{-64'sd432928099,  -64'sd1327727011, -64'sd974050063},
    '{ 64'sd331541774,  -64'sd1304710023,  64'sd1044303962},
    '{64'sd0, 64'sd0, 64'sd0}, '{64'sd0, 64'sd0, 64'sd0}, '{64'sd0, 64'sd0, 64'sd0},
    '{64'sd0, 64'sd0, 64'sd0}, '{64'sd0, 64'sd0, 64'sd0}, '{64'sd0, 64'sd0, 64'sd0},
    '{64'sd0, 64'sd0, 64'sd0}, '{64'sd0, 64'sd0, 64'sd0}, '{64'sd0, 64'sd0, 64'sd0},
    '{64'sd0, 64'sd0, 64'sd0}, '{64'sd0, 64'sd0, 64'sd0}
  };
  localparam longint W_OUT_N [UNIT_SLOTS] = '{
    64'sd487953865, 64'sd146187643, -64'sd469561163, 64'sd247502966, -64'sd126732938,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };
  localparam longint W_SKIP_N [NUM_IN] = '{-64'sd59409970, 64'sd34295714, -64'sd296352869};
  localparam longint B_HID_N [UNIT_SLOTS] = '{
    64'sd711245406, -64'sd6038161283, 64'sd672422209, 64'sd3816280809, 64'sd2470344776,
    64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
  };
  localparam longint B_OUT_N = 64'sd639504061;

  localparam longint unsigned IN_DEN   = 64'd244140625;
  localparam longint unsigned NANO_DEN = 64'd1000000000;
  localparam longint unsigned Q30_U    = 64'd1073741824;
  localparam longint          Q30_S    = 64'sd1073741824;

  // shift-subtract divide, elaboration use only
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    int b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // input weight with the 1/1000 scaling folded in, Q(frac+10), half away from zero
  function automatic longint scale_in(longint v, int frac);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = ((m << (frac - 2)) + IN_DEN / 2) / IN_DEN;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // plain Q(frac) weight, half away from zero
  function automatic longint scale_q(longint v, int frac);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    m = ((m << frac) + NANO_DEN / 2) / NANO_DEN;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // row < units is a hidden unit, the row after them is the direct path
  function automatic longint in_coef(int row, int col, int frac, int units);
    if (row < units) begin
      return scale_in(W_IN_N[row][col], frac);
    end
    return scale_in(W_SKIP_N[col], frac);
  endfunction

  function automatic longint hid_bias(int row, int frac, int units);
    if (row < units) begin
      return scale_q(B_HID_N[row], frac);
    end
    return 64'sd0;
  endfunction

  function automatic longint out_coef(int unit_no, int frac);
    return scale_q(W_OUT_N[unit_no], frac);
  endfunction

  function automatic longint out_bias(int frac);
    return scale_q(B_OUT_N, frac);
  endfunction

  // exp(-a), a in Q30 up to 8: series on a/16 then four squarings
  function automatic longint unsigned exp_neg_q30(longint unsigned a);
    longint y;
    longint term;
    longint sum;
    longint p;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned e;
    int k;
    y    = longint'(a >> 4);
    term = Q30_S;
    sum  = Q30_S;
    for (k = 1; k <= 12; k++) begin
      p    = term * y;
      mag  = (p < 0) ? longint'(-p) : longint'(p);
      q    = udiv64(mag, longint'(k) << 30);
      term = (p < 0) ? longint'(q) : -longint'(q);
      sum  = sum + term;
    end
    e = (sum < 0) ? 64'd0 : longint'(sum);
    for (k = 0; k < 4; k++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    return e;
  endfunction

  // tanh at the midpoint of table interval idx, Q(frac)
  function automatic longint unsigned tanh_entry(int idx, int frac, int depth);
    longint unsigned a;
    longint unsigned t;
    longint unsigned num;
    longint unsigned den;
    a = udiv64(longint'(8 * idx + 4) << 30, longint'(depth));
    t = exp_neg_q30(a);
    if (t > Q30_U) begin
      t = Q30_U;
    end
    num = Q30_U - t;
    den = Q30_U + t;
    return udiv64((num << frac) + (den >> 1), den);
  endfunction

endpackage

/* rtl/mlp_steering_from_guide_sensors_top.sv */
// Top level of the guide-sensor steering network: config registers, pipeline control, rules.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_stall    left, mid, right guide, aux_a, aux_b (12 bit each)
//   out_     out  out_valid / out_stall  steer_command (10 bit), rule_applied (3 bit)
//   cfg_     in   cfg_valid / cfg_ready  cfg_index (2 bit), cfg_data (12 bit)
//
// Seven register stages: input products, pre-activation, tanh index, tanh table read,
// output products, network sum, command and rules. One beat per cycle while out_stall is low.
// Each stage holds its valid bit and loads when empty or when the stage after it moves,
// so bubbles close up under a stall and nothing is dropped or repeated.
// Reset clears the valid bits and loads the threshold and centre registers; cfg_ready is
// always high.
module mlp_steering_from_guide_sensors_top import mlpsg_pkg::*; #(
  parameter int HIDDEN_UNITS     = 5,
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int COEF_FRAC_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [RAW_W-1:0]      in_left_guide,
  input  logic [RAW_W-1:0]      in_mid_guide,
  input  logic [RAW_W-1:0]      in_right_guide,
  input  logic [RAW_W-1:0]      in_aux_a,
  input  logic [RAW_W-1:0]      in_aux_b,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CMD_W-1:0]      out_steer_command,
  output logic [RULE_W-1:0]     out_rule_applied,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [RAW_W-1:0] edge_thr_r;
  logic [RAW_W-1:0] cross_thr_r;
  logic [CMD_W-1:0] center_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_thr_r  <= 12'd100;
      cross_thr_r <= 12'd3103;
      center_r    <= 10'd500;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_EDGE_THRESHOLD:  edge_thr_r  <= cfg_data;
        CFG_CROSS_THRESHOLD: cross_thr_r <= cfg_data;
        CFG_CENTER_VALUE:    center_r    <= cfg_data[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] v_nxt;
  logic [PIPE_STAGES-1:0] rdy;

  always_comb begin
    rdy[PIPE_STAGES-1] = !v_r[PIPE_STAGES-1] || !out_stall;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < PIPE_STAGES; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[PIPE_STAGES-1];

  // lost-edge and crossing rules, decided on entry
  logic  left_lost;
  logic  right_lost;
  logic  crossing;
  side_t side_nxt;
  side_t side_r [PIPE_STAGES-1];

  always_comb begin
    left_lost  = in_left_guide < edge_thr_r;
    right_lost = in_right_guide < edge_thr_r;
    crossing   = (in_aux_a > cross_thr_r) && (in_aux_b > cross_thr_r);
    side_nxt   = '{rule: RULE_NET, cmd: '0};
    if (crossing) begin
      side_nxt.rule = RULE_CROSS;
      side_nxt.cmd  = (center_r > CMD_MAX) ? CMD_MAX : center_r;
    end else if (left_lost && right_lost) begin
      side_nxt.rule = RULE_BOTH_LOST;
      side_nxt.cmd  = (in_aux_a > in_aux_b) ? CMD_MAX : '0;
    end else if (left_lost) begin
      side_nxt.rule = RULE_LEFT_LOST;
      side_nxt.cmd  = '0;
    end else if (right_lost) begin
      side_nxt.rule = RULE_RIGHT_LOST;
      side_nxt.cmd  = CMD_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side_r[0] <= side_nxt;
    end
    for (int k = 1; k < PIPE_STAGES - 1; k++) begin
      if (rdy[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  logic signed [COEF_FRAC_BITS+9:0] pre [HIDDEN_UNITS];
  logic signed [COEF_FRAC_BITS+9:0] skip;
  logic signed [COEF_FRAC_BITS+1:0] th [HIDDEN_UNITS];

  mlpsg_hidden #(
    .HIDDEN_UNITS   (HIDDEN_UNITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_hidden (
    .clk         (clk),
    .en          (rdy),
    .left_guide  (in_left_guide),
    .mid_guide   (in_mid_guide),
    .right_guide (in_right_guide),
    .pre         (pre),
    .skip        (skip)
  );

  mlpsg_tanh #(
    .HIDDEN_UNITS     (HIDDEN_UNITS),
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
    .COEF_FRAC_BITS   (COEF_FRAC_BITS)
  ) u_tanh (
    .clk (clk),
    .en  (rdy),
    .pre (pre),
    .th  (th)
  );

  mlpsg_out #(
    .HIDDEN_UNITS   (HIDDEN_UNITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_out (
    .clk           (clk),
    .en            (rdy),
    .skip          (skip),
    .th            (th),
    .center_value  (center_r),
    .side          (side_r[PIPE_STAGES-2]),
    .steer_command (out_steer_command),
    .rule_applied  (out_rule_applied)
  );

endmodule

/* rtl/mlpsg_hidden.sv */
// Input layer: constant-weight products, then summed, rounded and biased pre-activations.
module mlpsg_hidden import mlpsg_pkg::*; #(
  parameter int HIDDEN_UNITS   = 5,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic [PIPE_STAGES-1:0]            en,
  input  logic [RAW_W-1:0]                  left_guide,
  input  logic [RAW_W-1:0]                  mid_guide,
  input  logic [RAW_W-1:0]                  right_guide,
  output logic signed [COEF_FRAC_BITS+9:0]  pre [HIDDEN_UNITS],
  output logic signed [COEF_FRAC_BITS+9:0]  skip
);

  localparam int CW    = COEF_FRAC_BITS + 4;
  localparam int PW    = CW + RAW_W + 1;
  localparam int ACC_W = PW + 2;
  localparam int PRE_W = COEF_FRAC_BITS + 10;
  localparam int ROWS  = HIDDEN_UNITS + 1;

  logic signed [RAW_W:0] raw [NUM_IN];

  assign raw[0] = $signed({1'b0, left_guide});
  assign raw[1] = $signed({1'b0, mid_guide});
  assign raw[2] = $signed({1'b0, right_guide});

  for (genvar gr = 0; gr < ROWS; gr++) begin : g_row
    localparam logic signed [CW-1:0] K [NUM_IN] = '{
      CW'(in_coef(gr, 0, COEF_FRAC_BITS, HIDDEN_UNITS)),
      CW'(in_coef(gr, 1, COEF_FRAC_BITS, HIDDEN_UNITS)),
      CW'(in_coef(gr, 2, COEF_FRAC_BITS, HIDDEN_UNITS))
    };
    localparam logic signed [PRE_W-1:0] BIAS =
      PRE_W'(hid_bias(gr, COEF_FRAC_BITS, HIDDEN_UNITS));

    logic signed [PW-1:0]    prod_r [NUM_IN];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [PRE_W-1:0] pre_nxt;
    logic signed [PRE_W-1:0] pre_r;

    always_comb begin
      acc     = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2]);
      acc_rnd = acc + (ACC_W'(1) <<< (IN_SHIFT - 1));
      acc_sh  = acc_rnd >>> IN_SHIFT;
      pre_nxt = PRE_W'(acc_sh) + BIAS;
    end

    always_ff @(posedge clk) begin
      if (en[ST_MUL_IN]) begin
        for (int j = 0; j < NUM_IN; j++) begin
          prod_r[j] <= PW'(K[j]) * PW'(raw[j]);
        end
      end
      if (en[ST_PRE]) begin
        pre_r <= pre_nxt;
      end
    end

    if (gr < HIDDEN_UNITS) begin : g_unit
      assign pre[gr] = pre_r;
    end else begin : g_skip
      assign skip = pre_r;
    end
  end

endmodule

/* rtl/mlpsg_tanh.sv */
// tanh activation: magnitude and table index, then registered table read with sign restore.
module mlpsg_tanh import mlpsg_pkg::*; #(
  parameter int HIDDEN_UNITS     = 5,
  parameter int TANH_TABLE_DEPTH = 256,
  parameter int COEF_FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic [PIPE_STAGES-1:0]            en,
  input  logic signed [COEF_FRAC_BITS+9:0]  pre [HIDDEN_UNITS],
  output logic signed [COEF_FRAC_BITS+1:0]  th [HIDDEN_UNITS]
);

  localparam int PRE_W = COEF_FRAC_BITS + 10;
  localparam int TH_W  = COEF_FRAC_BITS + 2;
  localparam int IDX_W = $clog2(TANH_TABLE_DEPTH);
  localparam int MW    = COEF_FRAC_BITS + 2 + IDX_W + 1;

  localparam logic [PRE_W-1:0]       SAT_LIM = PRE_W'(4) << COEF_FRAC_BITS;
  localparam logic signed [TH_W-1:0] TH_ONE  = TH_W'(1) <<< COEF_FRAC_BITS;

  // midpoint table over |x| in [0,4), built at elaboration
  logic [COEF_FRAC_BITS:0] rom [TANH_TABLE_DEPTH];

  for (genvar gi = 0; gi < TANH_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint unsigned TV = tanh_entry(gi, COEF_FRAC_BITS, TANH_TABLE_DEPTH);
    assign rom[gi] = TV[COEF_FRAC_BITS:0];
  end

  for (genvar gu = 0; gu < HIDDEN_UNITS; gu++) begin : g_unit
    logic [PRE_W-1:0]       mag;
    logic [MW-1:0]          scaled;
    logic [IDX_W-1:0]       idx_r;
    logic                   sat_r;
    logic                   neg_r;
    logic signed [TH_W-1:0] val;
    logic signed [TH_W-1:0] th_r;

    always_comb begin
      mag    = pre[gu][PRE_W-1] ? PRE_W'(-pre[gu]) : PRE_W'(pre[gu]);
      scaled = MW'(mag[COEF_FRAC_BITS+1:0]) * MW'(TANH_TABLE_DEPTH);
      val    = sat_r ? TH_ONE : $signed({1'b0, rom[idx_r]});
    end

    always_ff @(posedge clk) begin
      if (en[ST_IDX]) begin
        idx_r <= scaled[COEF_FRAC_BITS+2 +: IDX_W];
        sat_r <= (mag >= SAT_LIM);
        neg_r <= pre[gu][PRE_W-1];
      end
      if (en[ST_ROM]) begin
        th_r <= neg_r ? -val : val;
      end
    end

    assign th[gu] = th_r;
  end

endmodule

/* rtl/mlpsg_out.sv */
// Output layer: weighted tanh products, sum with direct path and bias, command scaling and rules.
module mlpsg_out import mlpsg_pkg::*; #(
  parameter int HIDDEN_UNITS   = 5,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic [PIPE_STAGES-1:0]            en,
  input  logic signed [COEF_FRAC_BITS+9:0]  skip,
  input  logic signed [COEF_FRAC_BITS+1:0]  th [HIDDEN_UNITS],
  input  logic [CMD_W-1:0]                  center_value,
  input  side_t                             side,
  output logic [CMD_W-1:0]                  steer_command,
  output logic [RULE_W-1:0]                 rule_applied
);

  localparam int F     = COEF_FRAC_BITS;
  localparam int PRE_W = F + 10;
  localparam int CW    = F + 4;
  localparam int WP_W  = CW + F + 2;
  localparam int HW    = WP_W + 4;
  localparam int Y_W   = F + 6;
  localparam int S_W   = F + 13;

  localparam logic signed [Y_W-1:0] K_BO = Y_W'(out_bias(F));
  localparam logic signed [S_W-1:0] GAIN = S_W'(200);

  logic signed [PRE_W-1:0] skip_idx_r;
  logic signed [PRE_W-1:0] skip_rom_r;
  logic signed [PRE_W-1:0] skip_mul_r;
  logic signed [WP_W-1:0]  wprod [HIDDEN_UNITS];

  for (genvar gu = 0; gu < HIDDEN_UNITS; gu++) begin : g_unit
    localparam logic signed [CW-1:0] K_OUT = CW'(out_coef(gu, F));
    logic signed [WP_W-1:0] wprod_r;

    always_ff @(posedge clk) begin
      if (en[ST_MUL_OUT]) begin
        wprod_r <= WP_W'(K_OUT) * WP_W'(th[gu]);
      end
    end

    assign wprod[gu] = wprod_r;
  end

  logic signed [HW-1:0]  hid;
  logic signed [HW-1:0]  hid_rnd;
  logic signed [Y_W-1:0] y_nxt;
  logic signed [Y_W-1:0] y_r;

  always_comb begin
    hid = '0;
    for (int u = 0; u < HIDDEN_UNITS; u++) begin
      hid = hid + HW'(wprod[u]);
    end
    hid_rnd = (hid + (HW'(1) <<< (F - 1))) >>> F;
    y_nxt   = Y_W'(skip_mul_r) + Y_W'(hid_rnd) + K_BO;
  end

  logic signed [S_W-1:0] s;
  logic signed [S_W-1:0] q;
  logic [CMD_W-1:0]      cmd_net;
  logic [CMD_W-1:0]      cmd_nxt;
  logic [CMD_W-1:0]      cmd_r;
  rule_t                 rule_r;

  always_comb begin
    s = S_W'(y_r) * GAIN + ($signed(S_W'(center_value)) <<< F);
    q = s >>> F;
    if (s < 0) begin
      cmd_net = '0;
    end else if (q > $signed(S_W'(CMD_MAX))) begin
      cmd_net = CMD_MAX;
    end else begin
      cmd_net = q[CMD_W-1:0];
    end
    cmd_nxt = (side.rule == RULE_NET) ? cmd_net : side.cmd;
  end

  always_ff @(posedge clk) begin
    if (en[ST_IDX]) begin
      skip_idx_r <= skip;
    end
    if (en[ST_ROM]) begin
      skip_rom_r <= skip_idx_r;
    end
    if (en[ST_MUL_OUT]) begin
      skip_mul_r <= skip_rom_r;
    end
    if (en[ST_SUM]) begin
      y_r <= y_nxt;
    end
    if (en[ST_CMD]) begin
      cmd_r  <= cmd_nxt;
      rule_r <= side.rule;
    end
  end

  assign steer_command = cmd_r;
  assign rule_applied  = rule_r;

endmodule

/* rtl/mlpsg_checker.sv */
// Port-level checks for the steering network top level, bound to every instance.
module mlpsg_checker import mlpsg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CMD_W-1:0]  out_steer_command,
  input logic [RULE_W-1:0] out_rule_applied
);

  // input only backs up when every stage is full and the output beat is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_steer_command <= CMD_MAX))
    else $error("steer command above range");

  a_lost_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rule_applied == RULE_LEFT_LOST || out_rule_applied == RULE_RIGHT_LOST
                   || out_rule_applied == RULE_BOTH_LOST))
    |-> (out_steer_command == '0 || out_steer_command == CMD_MAX))
    else $error("lost-edge rule without full steer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_steer_command) && $stable(out_rule_applied)))
    else $error("held output beat changed");

endmodule

bind mlp_steering_from_guide_sensors_top mlpsg_checker u_mlpsg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_steer_command (out_steer_command),
  .out_rule_applied  (out_rule_applied)
);
